/* rtl/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

/* rtl/twt_pkg.sv */
`default_nettype none
package twt_pkg;
    localparam logic [2:0] FN_NEGOTIATE = 3'd0;
    localparam logic [2:0] FN_TEARDOWN  = 3'd1;
    localparam logic [2:0] FN_SCHEDULE  = 3'd2;
    localparam logic [2:0] FN_QUERY     = 3'd3;
    localparam logic [2:0] FN_RESET     = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_INACTIVE = 2'd3;

    localparam logic [31:0] SLEEP_CAP_RESET = 32'd30000000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] now_us;
        logic [7:0]  slot;
        logic [63:0] request_interval;
        logic [63:0] request_duration;
        logic [63:0] request_target;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  assigned_slot;
        logic [63:0] agreed_interval;
        logic [63:0] agreed_target;
        logic [63:0] remaining_us;
        logic [31:0] sleep_us;
        logic        may_sleep;
    } t_out;

    typedef struct packed {
        logic [63:0] interval;
        logic [63:0] duration;
        logic [63:0] target;
    } t_flow;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL_ONES : s[63:0];
    endfunction
endpackage
`default_nettype wire

/* rtl/twt_ram.sv */
`default_nettype none
module twt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/twt_div.sv */
`default_nettype none
// 64-bit restoring divider, one quotient bit per cycle
module twt_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic      [63:0] o_quo
);
    logic [63:0] r_rem, r_quo, r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_sh;
    logic [64:0] w_diff;

    assign w_sh   = {r_rem, r_quo[63]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[64]) begin
                    r_rem <= w_diff[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/twt_flow_wake_scheduler.sv */
`default_nettype none
// negotiate, teardown, schedule and reset go from idle to the done state, then the strobe
// query reads each flow in turn; one at or past its target takes the 64-bit divide path
// one transaction at a time; busy is low again in the result strobe cycle
// synchronous active-low reset clears valid bits, cap returns to 30000000
// the receiver cannot stall: the result strobe is high for one cycle only
`include "assert_macros.svh"
module twt_flow_wake_scheduler
    import twt_pkg::*;
#(
    parameter int FLOWS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_in         i_in,
    output logic             o_strobe,
    output t_out             o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int AW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_QRD, S_QEVAL, S_QDIV, S_QMUL0, S_QSUM, S_QMUL1, S_QNEXT, S_DONE
    } t_state;

    t_state r_state;
    logic [63:0] r_now;
    logic [31:0] r_cap;
    logic [FLOWS-1:0] r_valid;
    logic [AW-1:0] r_idx;
    logic [63:0] r_soon;
    logic r_have, r_wake;
    logic [63:0] r_q;
    logic [63:0] r_p0;
    logic [31:0] r_p1, r_p2;
    logic [63:0] r_start;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_flow         w_wdata;
    t_flow         w_rdata;
    logic          w_dstart, w_ddone;
    logic [63:0]   w_quo;

    twt_ram #(.WIDTH($bits(t_flow)), .DEPTH(FLOWS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_idx), .o_rdata(w_rdata)
    );

    twt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(r_now - w_rdata.target), .i_den(w_rdata.interval),
        .o_done(w_ddone), .o_quo(w_quo)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? r_cap : 32'd0;
    assign busy   = (r_state != S_IDLE);

    // negotiate / schedule combinational path on the accepted transaction
    logic          w_free_any;
    logic [AW-1:0] w_free;
    logic [63:0]   w_niv, w_ntg, w_stg;
    logic          w_slot_ok;
    logic [AW-1:0] w_slot;
    always_comb begin
        w_free_any = 1'b0;
        w_free = '0;
        for (int i = FLOWS-1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_any = 1'b1;
                w_free = AW'(i);
            end
        end
        w_niv = (i_in.request_interval < i_in.request_duration)
              ? sat_add(i_in.request_duration, i_in.request_duration)
              : i_in.request_interval;
        w_ntg = (i_in.request_target == 64'd0) ? sat_add(i_in.now_us, w_niv)
              : i_in.request_target;
        w_stg = (i_in.request_target == 64'd0)
              ? sat_add(i_in.now_us, i_in.request_interval) : i_in.request_target;
        w_slot_ok = ({24'd0, i_in.slot} < 32'(FLOWS));
        w_slot = i_in.slot[AW-1:0];
    end

    logic w_acc;
    assign w_acc = start && !busy;

    always_comb begin
        w_we = 1'b0;
        w_waddr = w_slot;
        w_wdata = t_flow'(0);
        if (w_acc) begin
            unique case (i_in.func)
                FN_NEGOTIATE: begin
                    w_we = (i_in.request_interval != 0) && (i_in.request_duration != 0)
                        && w_free_any;
                    w_waddr = w_free;
                    w_wdata = '{w_niv, i_in.request_duration, w_ntg};
                end
                FN_SCHEDULE: begin
                    w_we = w_slot_ok && (i_in.request_interval != 0);
                    w_wdata = '{i_in.request_interval,
                        (i_in.request_duration == 0) ? 64'd1 : i_in.request_duration, w_stg};
                end
                default: w_we = 1'b0;
            endcase
        end
    end

    // query evaluation on read data
    logic [63:0] w_now;
    logic [63:0] w_du, w_nx;
    logic        w_inside;
    assign w_now = r_now;
    assign w_du = (w_rdata.duration == 0) ? 64'd1 : w_rdata.duration;
    always_comb begin
        w_inside = (w_now < sat_add(r_start, w_du));
        w_nx = sat_add(r_start, w_rdata.interval);
    end
    assign w_dstart = (r_state == S_QEVAL) && r_valid[r_idx] && (w_rdata.interval != 0)
        && (w_rdata.target != 0) && !(w_now < w_rdata.target);

    logic [63:0] w_rem;
    assign w_rem = (!r_wake && r_have && (r_soon > w_now)) ? r_soon - w_now : 64'd0;

    // result of the accepted transaction, or of the finished query
    t_out n_out;
    always_comb begin
        n_out = t_out'(0);
        if (r_state == S_QNEXT) begin
            n_out.remaining_us = w_rem;
            n_out.sleep_us = (w_rem > {32'd0, r_cap}) ? r_cap : w_rem[31:0];
            n_out.may_sleep = (w_rem != 64'd0);
        end else begin
            unique case (i_in.func)
                FN_NEGOTIATE: begin
                    if (i_in.request_interval == 0 || i_in.request_duration == 0)
                        n_out.status = ST_INVALID;
                    else if (!w_free_any)
                        n_out.status = ST_FULL;
                    else begin
                        n_out.assigned_slot = 3'(w_free);
                        n_out.agreed_interval = w_niv;
                        n_out.agreed_target = w_ntg;
                    end
                end
                FN_TEARDOWN: begin
                    if (!w_slot_ok)
                        n_out.status = ST_INVALID;
                    else begin
                        n_out.assigned_slot = i_in.slot[2:0];
                        if (!r_valid[w_slot])
                            n_out.status = ST_INACTIVE;
                    end
                end
                FN_SCHEDULE: begin
                    if (!w_slot_ok)
                        n_out.status = ST_INVALID;
                    else begin
                        n_out.assigned_slot = i_in.slot[2:0];
                        if (i_in.request_interval == 0)
                            n_out.status = ST_INVALID;
                        else begin
                            n_out.agreed_interval = i_in.request_interval;
                            n_out.agreed_target = w_stg;
                        end
                    end
                end
                FN_QUERY: n_out.status = ST_OK;
                FN_RESET: n_out.status = ST_OK;
                default: n_out.status = ST_INVALID;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_cap    <= SLEEP_CAP_RESET;
            o_strobe <= 1'b0;
            r_idx    <= '0;
        end else begin
            o_strobe <= (r_state == S_DONE);
            if (psel && penable && pwrite && paddr == 2'd0) begin
                r_cap <= pwdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_now <= i_in.now_us;
                        o_out <= n_out;
                        r_state <= (i_in.func == FN_QUERY) ? S_QRD : S_DONE;
                        unique case (i_in.func)
                            FN_NEGOTIATE: begin
                                if (w_we)
                                    r_valid[w_waddr] <= 1'b1;
                            end
                            FN_TEARDOWN: begin
                                if (w_slot_ok)
                                    r_valid[w_slot] <= 1'b0;
                            end
                            FN_SCHEDULE: begin
                                if (w_we)
                                    r_valid[w_waddr] <= 1'b1;
                            end
                            FN_QUERY: begin
                                r_idx  <= '0;
                                r_have <= 1'b0;
                                r_wake <= 1'b0;
                            end
                            FN_RESET: r_valid <= '0;
                            default: ;
                        endcase
                    end
                end
                S_QRD: r_state <= S_QEVAL;
                S_QEVAL: begin
                    if (!r_valid[r_idx] || w_rdata.interval == 0) begin
                        r_state <= S_QNEXT;
                    end else if (w_rdata.target == 0 || w_now < w_rdata.target) begin
                        if (!r_have || (w_rdata.target == 0 ? sat_add(w_now,
                                w_rdata.interval) : w_rdata.target) < r_soon)
                            r_soon <= (w_rdata.target == 0)
                                ? sat_add(w_now, w_rdata.interval) : w_rdata.target;
                        r_have <= 1'b1;
                        r_state <= S_QNEXT;
                    end else begin
                        r_state <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (w_ddone) begin
                        r_q <= w_quo;
                        r_state <= S_QMUL0;
                    end
                end
                S_QMUL0: begin
                    r_p0 <= r_q[31:0] * w_rdata.interval[31:0];
                    r_p1 <= r_q[63:32] * w_rdata.interval[31:0];
                    r_p2 <= r_q[31:0] * w_rdata.interval[63:32];
                    r_state <= S_QSUM;
                end
                S_QSUM: begin
                    r_start <= w_rdata.target + r_p0 + {r_p1 + r_p2, 32'd0};
                    r_state <= S_QMUL1;
                end
                S_QMUL1: begin
                    if (w_inside)
                        r_wake <= 1'b1;
                    else begin
                        if (!r_have || w_nx < r_soon)
                            r_soon <= w_nx;
                        r_have <= 1'b1;
                    end
                    r_state <= S_QNEXT;
                end
                S_QNEXT: begin
                    if (32'(r_idx) == FLOWS - 1) begin
                        o_out <= n_out;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                        r_state <= S_QRD;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_strobe_once, i_clk, i_rst_n, o_strobe, !o_strobe)
    `ASSERT_IMPL(a_idle_on_strobe, i_clk, i_rst_n, o_strobe, r_state == S_IDLE)
    `ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, w_acc, busy)
endmodule
`default_nettype wire
